// ===== design/sgbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sgbq_pkg
// Shared types and constants of the structured grid boundary quad generator:
// register indexes, face codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sgbq_pkg;

  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ID_W        = 30;
  localparam int unsigned QN_W        = 23;
  localparam int unsigned FACE_W      = 3;
  localparam int unsigned FACE_CODES  = 2 ** FACE_W;
  localparam int unsigned MAX_DIM_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  localparam logic [FACE_W-1:0] FACE_X_LO = 3'd0;
  localparam logic [FACE_W-1:0] FACE_X_HI = 3'd1;
  localparam logic [FACE_W-1:0] FACE_Y_LO = 3'd2;
  localparam logic [FACE_W-1:0] FACE_Y_HI = 3'd3;
  localparam logic [FACE_W-1:0] FACE_Z_LO = 3'd4;
  localparam logic [FACE_W-1:0] FACE_Z_HI = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_MUL1,
    ST_MUL2,
    ST_EMIT,
    ST_EMPTY
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic norm_step;
    logic mul1;
    logic mul2;
    logic emit;
    logic emit_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic any_quads;
    logic pos_ok;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/sgbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgbq_ctrl
// Sequencer of one request: take it, walk the counters to a valid quad, run
// the two multiply steps and hand the quad, or none, to the output register.
// ----------------------------------------------------------------------------
module sgbq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sgbq_pkg::dp_sts_t sts_i,
  output sgbq_pkg::dp_cmd_t cmd_o
);

  sgbq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgbq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sgbq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sgbq_pkg::ST_NORM;
      end
      sgbq_pkg::ST_NORM: begin
        if (!sts_i.any_quads) begin
          state_d = sgbq_pkg::ST_EMPTY;
        end else if (sts_i.pos_ok) begin
          state_d = sgbq_pkg::ST_MUL1;
        end
      end
      sgbq_pkg::ST_MUL1: state_d = sgbq_pkg::ST_MUL2;
      sgbq_pkg::ST_MUL2: state_d = sgbq_pkg::ST_EMIT;
      sgbq_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = sgbq_pkg::ST_IDLE;
      end
      sgbq_pkg::ST_EMPTY: begin
        if (sts_i.out_free) state_d = sgbq_pkg::ST_IDLE;
      end
      default: state_d = sgbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sgbq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      sgbq_pkg::ST_NORM:  cmd_o.norm_step  = sts_i.any_quads && !sts_i.pos_ok;
      sgbq_pkg::ST_MUL1:  cmd_o.mul1       = 1'b1;
      sgbq_pkg::ST_MUL2:  cmd_o.mul2       = 1'b1;
      sgbq_pkg::ST_EMIT:  cmd_o.emit       = sts_i.out_free;
      sgbq_pkg::ST_EMPTY: cmd_o.emit_empty = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== design/sgbq_dp.sv =====
// ----------------------------------------------------------------------------
// sgbq_dp
// Datapath: face and loop counters, point and cell id arithmetic in two
// multiply steps, and the output register.
// ----------------------------------------------------------------------------
module sgbq_dp #(
  parameter int unsigned MAX_DIM = sgbq_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sgbq_pkg::CFG_W-1:0]  dim_x_i,
  input  logic [sgbq_pkg::CFG_W-1:0]  dim_y_i,
  input  logic [sgbq_pkg::CFG_W-1:0]  dim_z_i,
  input  logic                        restart_i,
  input  sgbq_pkg::dp_cmd_t           cmd_i,
  output sgbq_pkg::dp_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sgbq_pkg::FACE_W-1:0] face_o,
  output logic [sgbq_pkg::ID_W-1:0]   point_a_o,
  output logic [sgbq_pkg::ID_W-1:0]   point_b_o,
  output logic [sgbq_pkg::ID_W-1:0]   point_c_o,
  output logic [sgbq_pkg::ID_W-1:0]   point_d_o,
  output logic [sgbq_pkg::ID_W-1:0]   cell_source_o,
  output logic [sgbq_pkg::QN_W-1:0]   quad_number_o,
  output logic                        last_o,
  output logic                        none_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned SZ_W   = 2 * DIM_W;
  localparam int unsigned YM_W   = CNT_W + DIM_W;
  localparam int unsigned CS_W   = 2 * CNT_W;
  localparam int unsigned PZ_W   = CNT_W + SZ_W;
  localparam int unsigned CZ_W   = CNT_W + CS_W;
  localparam int unsigned FACE_W = sgbq_pkg::FACE_W;
  localparam int unsigned ID_W   = sgbq_pkg::ID_W;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [sgbq_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  logic [DIM_W-1:0] nx, ny, nz;
  logic [CNT_W-1:0] lx, ly, lz;
  logic             gx, gy, gz;
  logic [sgbq_pkg::FACE_CODES-1:0] has_v;

  assign nx = eff_dim(dim_x_i);
  assign ny = eff_dim(dim_y_i);
  assign nz = eff_dim(dim_z_i);
  assign lx = CNT_W'(nx - DIM_W'(1));
  assign ly = CNT_W'(ny - DIM_W'(1));
  assign lz = CNT_W'(nz - DIM_W'(1));
  assign gx = (lx != '0);
  assign gy = (ly != '0);
  assign gz = (lz != '0);

  always_comb begin
    has_v    = '0;
    has_v[0] = gy && gz;
    has_v[1] = gx && gy && gz;
    has_v[2] = gx && gz;
    has_v[3] = gy && gx && gz;
    has_v[4] = gx && gy;
    has_v[5] = gz && gx && gy;
  end

  // Loop counters
  logic [FACE_W-1:0]         face_q, face_d;
  logic [CNT_W-1:0]          outer_q, outer_d, inner_q, inner_d;
  logic [sgbq_pkg::QN_W-1:0] quad_q, quad_d;

  logic [CNT_W-1:0] olen, ilen, inner_inc, outer_inc;
  logic             over, face_bad, inner_bad, later, last_d;

  always_comb begin
    if (face_q inside {sgbq_pkg::FACE_X_LO, sgbq_pkg::FACE_X_HI}) begin
      olen = ly;
      ilen = lz;
    end else if (face_q inside {sgbq_pkg::FACE_Y_LO, sgbq_pkg::FACE_Y_HI}) begin
      olen = lx;
      ilen = lz;
    end else begin
      olen = lx;
      ilen = ly;
    end
  end

  assign over      = (face_q > sgbq_pkg::FACE_Z_HI);
  assign face_bad  = !has_v[face_q] || (outer_q >= olen);
  assign inner_bad = (inner_q >= ilen);
  assign inner_inc = inner_q + CNT_W'(1);
  assign outer_inc = outer_q + CNT_W'(1);

  always_comb begin
    later = 1'b0;
    for (int f = 0; f < sgbq_pkg::FACE_CODES; f++) begin
      later = later | (has_v[f] && (FACE_W'(f) > face_q));
    end
  end

  always_comb begin
    face_d  = face_q;
    outer_d = outer_q;
    inner_d = inner_q;
    quad_d  = quad_q;
    last_d  = 1'b0;
    if (cmd_i.take && restart_i) begin
      face_d  = '0;
      outer_d = '0;
      inner_d = '0;
      quad_d  = '0;
    end else if (cmd_i.norm_step) begin
      if (over) begin
        face_d  = '0;
        outer_d = '0;
        inner_d = '0;
        quad_d  = '0;
      end else if (face_bad) begin
        face_d  = face_q + FACE_W'(1);
        outer_d = '0;
        inner_d = '0;
      end else if (inner_bad) begin
        inner_d = '0;
        outer_d = outer_inc;
      end
    end else if (cmd_i.emit_empty) begin
      face_d  = '0;
      outer_d = '0;
      inner_d = '0;
      quad_d  = '0;
    end else if (cmd_i.emit) begin
      quad_d  = quad_q + sgbq_pkg::QN_W'(1);
      inner_d = inner_inc;
      if (inner_inc >= ilen) begin
        inner_d = '0;
        outer_d = outer_inc;
        if (outer_inc >= olen) begin
          outer_d = '0;
          if (!later) begin
            last_d  = 1'b1;
            face_d  = '0;
            quad_d  = '0;
          end else begin
            face_d = face_q + FACE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q  <= '0;
      outer_q <= '0;
      inner_q <= '0;
      quad_q  <= '0;
    end else begin
      face_q  <= face_d;
      outer_q <= outer_d;
      inner_q <= inner_d;
      quad_q  <= quad_d;
    end
  end

  // Corner and cell coordinates of the current quad
  logic [CNT_W-1:0] px, py, pz, cx, cy, cz, cyc, cys;

  assign cyc = gx ? lx : CNT_W'(1);
  assign cys = gy ? ly : CNT_W'(1);

  always_comb begin
    case (face_q)
      sgbq_pkg::FACE_X_LO: begin
        px = '0;      py = outer_q; pz = inner_q;
        cx = '0;      cy = outer_q; cz = inner_q;
      end
      sgbq_pkg::FACE_X_HI: begin
        px = lx;                   py = outer_q; pz = inner_q;
        cx = lx - CNT_W'(1);       cy = outer_q; cz = inner_q;
      end
      sgbq_pkg::FACE_Y_LO: begin
        px = outer_q; py = '0;     pz = inner_q;
        cx = outer_q; cy = '0;     cz = inner_q;
      end
      sgbq_pkg::FACE_Y_HI: begin
        px = outer_q; py = ly;                 pz = inner_q;
        cx = outer_q; cy = ly - CNT_W'(1);     cz = inner_q;
      end
      sgbq_pkg::FACE_Z_LO: begin
        px = outer_q; py = inner_q; pz = '0;
        cx = outer_q; cy = inner_q; cz = '0;
      end
      default: begin
        px = outer_q; py = inner_q; pz = lz;
        cx = outer_q; cy = inner_q; cz = lz - CNT_W'(1);
      end
    endcase
  end

  // First multiply step: strides and in-plane products
  logic [SZ_W-1:0]  sz_q;
  logic [YM_W-1:0]  ymul_q;
  logic [CS_W-1:0]  czs_q, cym_q;
  logic [CNT_W-1:0] px_q, pz_q, cx_q, cz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      sz_q   <= SZ_W'(nx) * SZ_W'(ny);
      ymul_q <= YM_W'(py) * YM_W'(nx);
      czs_q  <= CS_W'(cyc) * CS_W'(cys);
      cym_q  <= CS_W'(cy) * CS_W'(cyc);
      px_q   <= px;
      pz_q   <= pz;
      cx_q   <= cx;
      cz_q   <= cz;
    end
  end

  // Second multiply step: base point id, cell id and corner offsets
  logic [PZ_W-1:0] zprod;
  logic [CZ_W-1:0] cprod;
  logic [ID_W-1:0] sy_w, sz_w, du, dv;
  logic [ID_W-1:0] pa_q, cell_q, du_q, dv_q, duv_q;

  assign zprod = PZ_W'(pz_q) * PZ_W'(sz_q);
  assign cprod = CZ_W'(cz_q) * CZ_W'(czs_q);
  assign sy_w  = ID_W'(nx);
  assign sz_w  = ID_W'(sz_q);

  always_comb begin
    case (face_q)
      sgbq_pkg::FACE_X_LO: begin du = sz_w;        dv = sy_w;        end
      sgbq_pkg::FACE_X_HI: begin du = sy_w;        dv = sz_w;        end
      sgbq_pkg::FACE_Y_LO: begin du = ID_W'(1);    dv = sz_w;        end
      sgbq_pkg::FACE_Y_HI: begin du = sz_w;        dv = ID_W'(1);    end
      sgbq_pkg::FACE_Z_LO: begin du = sy_w;        dv = ID_W'(1);    end
      default:             begin du = ID_W'(1);    dv = sy_w;        end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      pa_q   <= ID_W'(zprod) + ID_W'(ymul_q) + ID_W'(px_q);
      cell_q <= ID_W'(cprod) + ID_W'(cym_q) + ID_W'(cx_q);
      du_q   <= du;
      dv_q   <= dv;
      duv_q  <= du + dv;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      face_o        <= face_q;
      point_a_o     <= pa_q;
      point_b_o     <= pa_q + du_q;
      point_c_o     <= pa_q + duv_q;
      point_d_o     <= pa_q + dv_q;
      cell_source_o <= cell_q;
      quad_number_o <= quad_q;
      last_o        <= last_d;
      none_o        <= 1'b0;
    end else if (cmd_i.emit_empty) begin
      face_o        <= '0;
      point_a_o     <= '0;
      point_b_o     <= '0;
      point_c_o     <= '0;
      point_d_o     <= '0;
      cell_source_o <= '0;
      quad_number_o <= '0;
      last_o        <= 1'b0;
      none_o        <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.any_quads = |has_v;
  assign sts_o.pos_ok    = !over && !face_bad && !inner_bad;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== design/structured_grid_boundary_quads.sv =====
// ----------------------------------------------------------------------------
// structured_grid_boundary_quads
// Boundary quad generator of an X by Y by Z structured grid: each request
// returns the next quad with its face, corner point ids, source cell id,
// ordinal and a last mark.
// ----------------------------------------------------------------------------
// When the counters already sit on a quad, a request passes the position
// check, the two multiply steps of the point and cell id arithmetic and the
// emit step, and the quad is then offered from the output register; the next
// request is taken after the emit step. Each counter fix-up the position
// sequencer makes (a finished row, an empty or skipped face, or a wrap) adds
// a further position step, and a quad holds in the emit step for as long as
// the output register still holds the previous one. The result waits in an
// output register, so a new request is taken while the previous quad is
// still pending. Dimensions are to be written on the configuration port only
// while no request is in flight; the block itself does not enforce this. A
// grid with fewer than two axes longer than one point answers every request
// with the none flag.
// ----------------------------------------------------------------------------
module structured_grid_boundary_quads #(
  parameter int unsigned MAX_DIM = sgbq_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sgbq_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sgbq_pkg::FACE_W-1:0]    face_o,
  output logic [sgbq_pkg::ID_W-1:0]      point_a_o,
  output logic [sgbq_pkg::ID_W-1:0]      point_b_o,
  output logic [sgbq_pkg::ID_W-1:0]      point_c_o,
  output logic [sgbq_pkg::ID_W-1:0]      point_d_o,
  output logic [sgbq_pkg::ID_W-1:0]      cell_source_o,
  output logic [sgbq_pkg::QN_W-1:0]      quad_number_o,
  output logic                           last_o,
  output logic                           none_o
);

  logic [sgbq_pkg::CFG_W-1:0] dim_x_q, dim_y_q, dim_z_q;
  sgbq_pkg::dp_cmd_t          cmd;
  sgbq_pkg::dp_sts_t          sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= sgbq_pkg::CFG_W'(1);
      dim_y_q <= sgbq_pkg::CFG_W'(1);
      dim_z_q <= sgbq_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgbq_pkg::REG_DIM_X: dim_x_q <= cfg_wdata_i;
        sgbq_pkg::REG_DIM_Y: dim_y_q <= cfg_wdata_i;
        sgbq_pkg::REG_DIM_Z: dim_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sgbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgbq_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dim_x_i       (dim_x_q),
    .dim_y_i       (dim_y_q),
    .dim_z_i       (dim_z_q),
    .restart_i     (restart_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .face_o        (face_o),
    .point_a_o     (point_a_o),
    .point_b_o     (point_b_o),
    .point_c_o     (point_c_o),
    .point_d_o     (point_d_o),
    .cell_source_o (cell_source_o),
    .quad_number_o (quad_number_o),
    .last_o        (last_o),
    .none_o        (none_o)
  );

endmodule
